### rtl/jkvl_pkg.sv
// Shared types and constants for the JSON key/value locator.
// Holds the scan state, result struct, match phases and config register codes.
// No dependencies.
package jkvl_pkg;

  localparam int MAX_KEY_BYTES    = 16;
  localparam int MAX_OBJECT_BYTES = 65536;

  localparam int KEY_STORE_BYTES = 16;
  localparam int KIDX_W          = $clog2(KEY_STORE_BYTES);
  localparam int KEY_CNT_W       = $clog2(MAX_KEY_BYTES + 1);
  localparam int KEY_LEN_W       = 5;
  localparam int KEY_WORD_W      = 64;
  localparam int CFG_DATA_W      = 64;
  localparam int CFG_IDX_W       = 2;
  localparam int POS_W           = $clog2(MAX_OBJECT_BYTES + 1);
  localparam int OFF_W           = 17;
  localparam int BYTE_W          = 8;

  localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_LO  = 2'd0,
    CFG_KEY_HI  = 2'd1,
    CFG_KEY_LEN = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_KEY   = 4'b0010,
    PH_COLON = 4'b0100,
    PH_VALUE = 4'b1000
  } phase_t;

  typedef struct packed {
    logic                 in_str;
    logic                 after_bs;
    phase_t               phase;
    logic [KEY_CNT_W-1:0] cnt;
    logic [POS_W-1:0]     pos;
    logic                 answered;
  } scan_state_t;

  typedef struct packed {
    logic             valid;
    logic             found;
    logic [OFF_W-1:0] offset;
  } scan_result_t;

endpackage

### rtl/jkvl_ifs.sv
// Valid/ready channel interfaces for the JSON key/value locator.
// Depends on jkvl_pkg for field widths.
interface jkvl_in_if;
  import jkvl_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;
  logic              last_byte;
  modport source (output valid, output text_byte, output last_byte, input ready);
  modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

interface jkvl_out_if;
  import jkvl_pkg::*;
  logic             valid;
  logic             ready;
  logic             key_found;
  logic [OFF_W-1:0] value_offset;
  modport source (output valid, output key_found, output value_offset, input ready);
  modport sink   (input valid, input key_found, input value_offset, output ready);
endinterface

### rtl/jkvl_step.sv
// Next-state and result logic for one text byte of the key scan.
// Purely combinational; depends on jkvl_pkg.
module jkvl_step (
  input  jkvl_pkg::scan_state_t            st,
  input  logic [jkvl_pkg::BYTE_W-1:0]      text_byte,
  input  logic                             last_byte,
  input  logic [jkvl_pkg::KEY_WORD_W-1:0]  key_lo,
  input  logic [jkvl_pkg::KEY_WORD_W-1:0]  key_hi,
  input  logic [jkvl_pkg::KEY_LEN_W-1:0]   key_len,
  output jkvl_pkg::scan_state_t            st_nxt,
  output jkvl_pkg::scan_result_t           res
);
  import jkvl_pkg::*;

  logic [KEY_STORE_BYTES-1:0][BYTE_W-1:0] key_arr;
  logic [KEY_LEN_W-1:0]                   in_use;
  logic [KIDX_W+KEY_CNT_W-1:0]            cnt_ext;
  logic [BYTE_W-1:0]                      key_byte;
  logic [POS_W-1:0]                       len;
  logic [POS_W-1:0]                       off;
  logic [POS_W+OFF_W-1:0]                 off_ext;
  logic                                   blank;
  logic                                   found;

  assign key_arr  = {key_hi, key_lo};
  assign in_use   = (key_len > MAX_KEY_BYTES) ? KEY_LEN_W'(MAX_KEY_BYTES) : key_len;
  assign cnt_ext  = {{KIDX_W{1'b0}}, st.cnt};
  assign key_byte = key_arr[cnt_ext[KIDX_W-1:0]];
  assign blank    = (text_byte == CH_SPACE) || (text_byte >= CH_TAB && text_byte <= CH_CR);
  assign len      = (st.pos >= POS_W'(MAX_OBJECT_BYTES)) ? POS_W'(MAX_OBJECT_BYTES)
                                                         : st.pos + 1'b1;
  assign off_ext  = {{OFF_W{1'b0}}, off};

  always_comb begin
    st_nxt = st;
    found  = 1'b0;
    off    = '0;
    res    = '0;

    if (!st.answered) begin
      case (st.phase)
        PH_KEY: begin
          if (st.cnt < in_use) begin
            if (text_byte == key_byte) begin
              st_nxt.cnt = st.cnt + 1'b1;
            end else begin
              st_nxt.phase = PH_IDLE;
            end
          end else begin
            st_nxt.phase = (text_byte == CH_QUOTE) ? PH_COLON : PH_IDLE;
          end
        end
        PH_COLON: begin
          if (text_byte == CH_COLON) begin
            st_nxt.phase = PH_VALUE;
          end else if (!blank) begin
            st_nxt.phase = PH_IDLE;
          end
        end
        PH_VALUE: begin
          if (!blank) begin
            found = 1'b1;
            off   = st.pos;
          end
        end
        default: ;
      endcase

      if (!found) begin
        // string tracking sees the phase already updated by this byte
        if (st.in_str) begin
          if (st.after_bs) begin
            st_nxt.after_bs = 1'b0;
          end else if (text_byte == CH_BSLASH) begin
            st_nxt.after_bs = 1'b1;
          end else if (text_byte == CH_QUOTE) begin
            st_nxt.in_str = 1'b0;
          end
        end else if (text_byte == CH_QUOTE) begin
          st_nxt.in_str = 1'b1;
          if (st_nxt.phase == PH_IDLE) begin
            st_nxt.phase = PH_KEY;
            st_nxt.cnt   = '0;
          end
        end
        // only whitespace after the colon: value starts at the object end
        if (last_byte && st_nxt.phase == PH_VALUE) begin
          found = 1'b1;
          off   = len;
        end
      end

      if (found) begin
        res.valid       = 1'b1;
        res.found       = 1'b1;
        res.offset      = off_ext[OFF_W-1:0];
        st_nxt.answered = 1'b1;
      end else if (last_byte) begin
        res.valid = 1'b1;
      end
    end

    if (last_byte) begin
      st_nxt.in_str   = 1'b0;
      st_nxt.after_bs = 1'b0;
      st_nxt.phase    = PH_IDLE;
      st_nxt.cnt      = '0;
      st_nxt.pos      = '0;
      st_nxt.answered = 1'b0;
    end else if (st.pos < POS_W'(MAX_OBJECT_BYTES)) begin
      st_nxt.pos = st.pos + 1'b1;
    end
  end

endmodule

### rtl/json_key_value_locator_unit.sv
// JSON key/value locator top level: input word register, scan step, result register.
// The scan state feeds back through one register; each result is registered.
// Throughput: one byte per cycle while the result register is not stalled.
// Reset (synchronous, rst_n low): scan state cleared, pipeline emptied,
// key bytes cleared and key length set to 1.
// Depends on jkvl_pkg, jkvl_ifs and jkvl_step.
module json_key_value_locator_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  jkvl_in_if.sink                           in_ch,
  jkvl_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [jkvl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [jkvl_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import jkvl_pkg::*;

  logic [KEY_WORD_W-1:0] key_lo_r;
  logic [KEY_WORD_W-1:0] key_hi_r;
  logic [KEY_LEN_W-1:0]  key_len_r;

  logic                  s1_valid_r;
  logic [BYTE_W-1:0]     s1_byte_r;
  logic                  s1_last_r;

  scan_state_t           st_r;
  scan_state_t           st_nxt;
  scan_result_t          res;

  logic                  out_valid_r;
  logic                  out_found_r;
  logic [OFF_W-1:0]      out_offset_r;

  logic                  adv;
  logic                  proc;

  assign adv          = !out_valid_r || out_ch.ready;
  assign proc         = s1_valid_r && adv;
  assign in_ch.ready  = !s1_valid_r || adv;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.key_found    = out_found_r;
  assign out_ch.value_offset = out_offset_r;

  jkvl_step u_step (
    .st        (st_r),
    .text_byte (s1_byte_r),
    .last_byte (s1_last_r),
    .key_lo    (key_lo_r),
    .key_hi    (key_hi_r),
    .key_len   (key_len_r),
    .st_nxt    (st_nxt),
    .res       (res)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_lo_r  <= '0;
      key_hi_r  <= '0;
      key_len_r <= KEY_LEN_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_LO:  key_lo_r  <= cfg_wdata[KEY_WORD_W-1:0];
        CFG_KEY_HI:  key_hi_r  <= cfg_wdata[KEY_WORD_W-1:0];
        CFG_KEY_LEN: key_len_r <= cfg_wdata[KEY_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // input word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r <= in_ch.text_byte;
      s1_last_r <= in_ch.last_byte;
    end
  end

  // scan state advances only when the byte moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.in_str   <= 1'b0;
      st_r.after_bs <= 1'b0;
      st_r.phase    <= PH_IDLE;
      st_r.cnt      <= '0;
      st_r.pos      <= '0;
      st_r.answered <= 1'b0;
    end else if (proc) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= proc && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && res.valid) begin
      out_found_r  <= res.found;
      out_offset_r <= res.offset;
    end
  end

  // a not-found result always carries offset zero
  a_nf_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_found_r |-> out_offset_r == '0)
    else $error("not-found result with nonzero offset");

  // the last byte of an object returns the scan to its start
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    proc && s1_last_r |=> st_r.pos == '0 && st_r.phase == PH_IDLE && !st_r.answered)
    else $error("scan state not cleared after last byte");

  // a last byte not yet answered must produce a result
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    proc && s1_last_r && !st_r.answered |=> out_valid_r)
    else $error("last byte gave no result");

  // match counter and position stay within their bounds
  a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.cnt <= KEY_CNT_W'(MAX_KEY_BYTES) && st_r.pos <= POS_W'(MAX_OBJECT_BYTES))
    else $error("scan counter out of range");

  // a stalled result is not overwritten
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(out_offset_r)
                                     && $stable(out_found_r))
    else $error("stalled result changed");

endmodule

### test/json_key_value_locator_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for json_key_value_locator_unit: streams JSON object text as byte words,
// predicts the located value offset of every object and checks each result word in order.
// Depends on jkvl_pkg, the channel interfaces in jkvl_ifs and the locator RTL.
module json_key_value_locator_unit_tb;
  import jkvl_pkg::*;

  localparam int CYCLE_LIMIT   = 50000;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] text;
    logic              last;
  } text_word_t;

  typedef struct packed {
    logic             found;
    logic [OFF_W-1:0] offset;
  } located_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_vld    = 1'b0;
  logic [BYTE_W-1:0]     in_byte   = '0;
  logic                  in_last   = 1'b0;
  logic                  out_rdy   = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  jkvl_in_if  in_ch();
  jkvl_out_if out_ch();

  assign in_ch.valid     = in_vld;
  assign in_ch.text_byte = in_byte;
  assign in_ch.last_byte = in_last;
  assign out_ch.ready    = out_rdy;

  json_key_value_locator_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Key registers as the block should hold them.
  logic [KEY_WORD_W-1:0] key_lo_cfg  = '0;
  logic [KEY_WORD_W-1:0] key_hi_cfg  = '0;
  logic [KEY_LEN_W-1:0]  key_len_cfg = 5'd1;

  // Scan state of the object in progress.
  logic                 sc_in_str   = 1'b0;
  logic                 sc_after_bs = 1'b0;
  phase_t               sc_phase    = PH_IDLE;
  logic [KEY_CNT_W-1:0] sc_cnt      = '0;
  logic [POS_W-1:0]     sc_pos      = '0;
  logic                 sc_answered = 1'b0;

  text_word_t        feed_q[$];
  located_t          located_q[$];
  logic [BYTE_W-1:0] txt[$];
  text_word_t        next_word;
  located_t          want;

  int words_queued = 0;
  int words_taken  = 0;
  int fail_count   = 0;
  int cycle_count  = 0;
  bit steady       = 1'b0;

  always #5 clk = ~clk;

  function automatic int key_span();
    return (key_len_cfg > MAX_KEY_BYTES) ? MAX_KEY_BYTES : int'(key_len_cfg);
  endfunction

  function automatic logic [BYTE_W-1:0] key_at(input int i);
    logic [KEY_WORD_W-1:0] w;
    w = (i < 8) ? key_lo_cfg : key_hi_cfg;
    return w[(i % 8) * 8 +: 8];
  endfunction

  function automatic bit is_blank(input logic [BYTE_W-1:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  task automatic clear_scan();
    sc_in_str   = 1'b0;
    sc_after_bs = 1'b0;
    sc_phase    = PH_IDLE;
    sc_cnt      = '0;
    sc_pos      = '0;
    sc_answered = 1'b0;
  endtask

  task automatic locate_step(input logic [BYTE_W-1:0] c, input logic last);
    logic [POS_W-1:0] len;
    logic             found;
    logic [OFF_W-1:0] off;
    located_t         res;
    len   = (sc_pos >= POS_W'(MAX_OBJECT_BYTES)) ? POS_W'(MAX_OBJECT_BYTES) : sc_pos + 1'b1;
    found = 1'b0;
    off   = '0;
    if (!sc_answered) begin
      case (sc_phase)
        PH_KEY: begin
          if (sc_cnt < key_span()) begin
            if (c == key_at(int'(sc_cnt))) begin
              sc_cnt = sc_cnt + 1'b1;
            end else begin
              sc_phase = PH_IDLE;
            end
          end else begin
            sc_phase = (c == CH_QUOTE) ? PH_COLON : PH_IDLE;
          end
        end
        PH_COLON: begin
          if (c == CH_COLON) begin
            sc_phase = PH_VALUE;
          end else if (!is_blank(c)) begin
            sc_phase = PH_IDLE;
          end
        end
        PH_VALUE: begin
          if (!is_blank(c)) begin
            found = 1'b1;
            off   = sc_pos;
          end
        end
        default: ;
      endcase
      if (!found) begin
        if (sc_in_str) begin
          if (sc_after_bs) begin
            sc_after_bs = 1'b0;
          end else if (c == CH_BSLASH) begin
            sc_after_bs = 1'b1;
          end else if (c == CH_QUOTE) begin
            sc_in_str = 1'b0;
          end
        end else if (c == CH_QUOTE) begin
          sc_in_str = 1'b1;
          // a pending match keeps running through a second quote
          if (sc_phase == PH_IDLE) begin
            sc_phase = PH_KEY;
            sc_cnt   = '0;
          end
        end
        if (last && sc_phase == PH_VALUE) begin
          found = 1'b1;
          off   = len;
        end
      end
      if (found) begin
        res.found  = 1'b1;
        res.offset = off;
        located_q.push_back(res);
        sc_answered = 1'b1;
      end else if (last) begin
        res = '0;
        located_q.push_back(res);
      end
    end
    if (last) begin
      clear_scan();
    end else if (sc_pos < POS_W'(MAX_OBJECT_BYTES)) begin
      sc_pos = sc_pos + 1'b1;
    end
  endtask

  // Driver: hold the word until taken, then advance from the feed queue.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_vld <= 1'b0;
    end else begin
      if (in_vld && in_ch.ready) begin
        words_taken++;
        locate_step(in_byte, in_last);
      end
      if (!in_vld || in_ch.ready) begin
        if (feed_q.size() > 0 && (steady || $urandom_range(99) >= 11)) begin
          next_word = feed_q.pop_front();
          in_vld  <= 1'b1;
          in_byte <= next_word.text;
          in_last <= next_word.last;
        end else begin
          in_vld <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result word with the oldest located answer.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_rdy <= 1'b0;
    end else begin
      if (out_ch.valid && out_rdy) begin
        if (located_q.size() == 0) begin
          $display("%0t: unexpected word found %0d offset %0d", $time,
                   out_ch.key_found, out_ch.value_offset);
          fail_count++;
        end else begin
          want = located_q.pop_front();
          if (out_ch.key_found !== want.found) begin
            $display("%0t: key_found expected %0d actual %0d", $time, want.found,
                     out_ch.key_found);
            fail_count++;
          end
          if (out_ch.value_offset !== want.offset) begin
            $display("%0t: value_offset expected %0d actual %0d", $time, want.offset,
                     out_ch.value_offset);
            fail_count++;
          end
        end
      end
      out_rdy <= steady || ($urandom_range(99) >= 11);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("json_key_value_locator_unit: mismatch");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_KEY_LO:  key_lo_cfg  = value;
      CFG_KEY_HI:  key_hi_cfg  = value;
      CFG_KEY_LEN: key_len_cfg = value[KEY_LEN_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_key_text(input string s, input logic [KEY_LEN_W-1:0] len_val);
    logic [2*KEY_WORD_W-1:0] packed_key;
    packed_key = '0;
    for (int i = 0; i < s.len() && i < KEY_STORE_BYTES; i++) packed_key[i*8 +: 8] = s[i];
    write_reg(CFG_KEY_LO, packed_key[KEY_WORD_W-1:0]);
    write_reg(CFG_KEY_HI, packed_key[2*KEY_WORD_W-1:KEY_WORD_W]);
    write_reg(CFG_KEY_LEN, CFG_DATA_W'(len_val));
  endtask

  task automatic set_key_random(input bit letters, input int unsigned len_val);
    logic [2*KEY_WORD_W-1:0] packed_key;
    logic [CFG_DATA_W-1:0]   len_word;
    for (int i = 0; i < KEY_STORE_BYTES; i++) begin
      packed_key[i*8 +: 8] = letters ? BYTE_W'("a" + $urandom_range(25)) :
                                       BYTE_W'($urandom_range(255));
    end
    // upper bits of the length word must be dropped
    len_word = {$urandom, $urandom};
    len_word[KEY_LEN_W-1:0] = len_val[KEY_LEN_W-1:0];
    write_reg(CFG_KEY_LO, packed_key[KEY_WORD_W-1:0]);
    write_reg(CFG_KEY_HI, packed_key[2*KEY_WORD_W-1:KEY_WORD_W]);
    write_reg(CFG_KEY_LEN, len_word);
  endtask

  // Wait for every word to be taken and answered, then let the pipeline drain.
  task automatic settle();
    while (words_taken != words_queued || located_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic emit_object();
    text_word_t w;
    foreach (txt[i]) begin
      w.text = txt[i];
      w.last = (i == txt.size() - 1);
      feed_q.push_back(w);
    end
    words_queued += txt.size();
    txt.delete();
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
  endtask

  task automatic put_key(input int n);
    for (int i = 0; i < n; i++) txt.push_back(key_at(i));
  endtask

  task automatic put_ws();
    int r;
    repeat ($urandom_range(2)) begin
      r = $urandom_range(5);
      txt.push_back((r == 5) ? CH_SPACE : BYTE_W'(CH_TAB + r));
    end
  endtask

  task automatic put_text();
    int r;
    repeat ($urandom_range(6)) begin
      r = $urandom_range(19);
      if (r == 0) begin
        txt.push_back(CH_BSLASH);
        txt.push_back(CH_QUOTE);
      end else if (r == 1) begin
        txt.push_back(CH_BSLASH);
        txt.push_back(CH_BSLASH);
      end else if (r == 2) begin
        txt.push_back(BYTE_W'(8'h80 + $urandom_range(127)));
      end else if (r == 3) begin
        txt.push_back(CH_COLON);
      end else begin
        txt.push_back(BYTE_W'("a" + $urandom_range(25)));
      end
    end
  endtask

  task automatic put_name();
    int pick;
    int n;
    pick = $urandom_range(99);
    n    = key_span();
    txt.push_back(CH_QUOTE);
    if (pick < 35) begin
      put_key(n);
    end else if (pick < 45 && n > 0) begin
      put_key(n - 1);
    end else if (pick < 55) begin
      put_key(n);
      txt.push_back(BYTE_W'("a" + $urandom_range(25)));
    end else if (pick < 62 && n > 0) begin
      put_key(n - 1);
      txt.push_back(key_at(n - 1) ^ 8'h01);
    end else begin
      put_text();
    end
    txt.push_back(CH_QUOTE);
  endtask

  task automatic put_scalar();
    case ($urandom_range(5))
      0: put_str($sformatf("%0d", $urandom_range(99999)));
      1: begin
        txt.push_back(CH_QUOTE);
        put_text();
        txt.push_back(CH_QUOTE);
      end
      2: put_str($urandom_range(1) ? "true" : "null");
      3: begin
        put_str("[-1,");
        put_ws();
        txt.push_back(CH_QUOTE);
        put_text();
        txt.push_back(CH_QUOTE);
        put_str("]");
      end
      4: begin
        // key text as a value string
        txt.push_back(CH_QUOTE);
        put_key(key_span());
        txt.push_back(CH_QUOTE);
      end
      default: put_str("0.5e3");
    endcase
  endtask

  task automatic put_member();
    put_name();
    put_ws();
    txt.push_back(CH_COLON);
    put_ws();
  endtask

  task automatic put_object();
    int m;
    int k;
    m = 1 + $urandom_range(3);
    put_str("{");
    put_ws();
    for (int i = 0; i < m; i++) begin
      if (i > 0) begin
        put_str(",");
        put_ws();
      end
      put_member();
      if ($urandom_range(3) == 0) begin
        k = 1 + $urandom_range(1);
        put_str("{");
        put_ws();
        for (int j = 0; j < k; j++) begin
          if (j > 0) put_str(",");
          put_member();
          put_scalar();
          put_ws();
        end
        put_str("}");
      end else begin
        put_scalar();
      end
      put_ws();
    end
    put_str("}");
  endtask

  function automatic logic [BYTE_W-1:0] noise_byte();
    int r;
    r = $urandom_range(19);
    case (r)
      0, 1:    return CH_QUOTE;
      2:       return CH_BSLASH;
      3:       return CH_COLON;
      4:       return CH_SPACE;
      5:       return BYTE_W'(CH_TAB + $urandom_range(4));
      6:       return (key_span() > 0) ? key_at($urandom_range(key_span() - 1)) : CH_QUOTE;
      default: return BYTE_W'($urandom_range(255));
    endcase
  endfunction

  task automatic random_object();
    int r;
    int cut;
    r = $urandom_range(99);
    if (r < 14) begin
      repeat (1 + $urandom_range(39)) txt.push_back(noise_byte());
    end else begin
      put_object();
      // break some of the well-formed objects
      if (r < 28) begin
        if ($urandom_range(1)) begin
          cut = 1 + $urandom_range(txt.size() - 1);
          while (txt.size() > cut) void'(txt.pop_back());
        end else begin
          txt[$urandom_range(txt.size() - 1)] = BYTE_W'($urandom_range(255));
        end
      end
    end
    emit_object();
  endtask

  task automatic run_random(input int amount);
    int start;
    start = words_queued;
    while (words_queued - start < amount) random_object();
    settle();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset key: one zero byte
    txt.push_back(CH_QUOTE);
    txt.push_back(8'h00);
    txt.push_back(CH_QUOTE);
    txt.push_back(CH_COLON);
    put_str("7");
    emit_object();
    txt.push_back(8'hFF);
    emit_object();
    settle();

    set_key_text("k", 5'd1);
    put_str("{\"k\":1}");
    emit_object();
    // only whitespace after the colon up to the last byte
    put_str("\"k\" : ");
    emit_object();
    txt.push_back(8'h00);
    emit_object();
    settle();

    // empty key matches ""
    write_reg(CFG_KEY_LEN, '0);
    put_str("\"\":5");
    emit_object();
    run_random(100);

    // length beyond the store acts as full length
    set_key_text("abcdefghijklmnop", 5'd31);
    run_random(300);

    write_reg(CFG_KEY_LO, '1);
    write_reg(CFG_KEY_HI, '1);
    write_reg(CFG_KEY_LEN, CFG_DATA_W'(MAX_KEY_BYTES));
    run_random(200);

    // raw quote and backslash inside the key
    set_key_text("a\"b\\", 5'd4);
    write_reg(CFG_SPARE_IDX, {$urandom, $urandom});
    run_random(250);

    for (int k = 0; k < 4; k++) begin
      if (k < 2) begin
        set_key_random(1'b1, 1 + $urandom_range(3));
      end else begin
        set_key_random(1'b0, 1 + $urandom_range(15));
      end
      steady = (k == 1);
      run_random(250);
    end
    steady = 1'b0;

    if (fail_count == 0 && located_q.size() == 0) begin
      $display("json_key_value_locator_unit: match");
    end else begin
      $display("json_key_value_locator_unit: mismatch");
    end
    $finish;
  end

endmodule
